// ===== hdl/semver_string_validator_macros.svh =====
// assertion macros for the semantic version checker
`ifndef SEMVER_STRING_VALIDATOR_MACROS_SVH
`define SEMVER_STRING_VALIDATOR_MACROS_SVH

`ifndef SYNTH
`define SVS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("semver_string_validator: check failed");
`define SVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("semver_string_validator: check failed");
`else
`define SVS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SVS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/svs_pkg.sv =====
package svs_pkg;

  localparam int NUM_W  = 60;
  localparam int OFS_W  = 10;
  localparam int DCNT_W = 5;

  localparam logic [2:0] PH_MAJOR = 3'd0;
  localparam logic [2:0] PH_MINOR = 3'd1;
  localparam logic [2:0] PH_PATCH = 3'd2;
  localparam logic [2:0] PH_PRE   = 3'd3;
  localparam logic [2:0] PH_BUILD = 3'd4;
  localparam logic [2:0] PH_ERR   = 3'd5;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [OFS_W-1:0] ofs_t;

endpackage

// ===== hdl/semver_string_validator.sv =====
// channel  direction  ports                                   when taken
// in       input      in_char_code, in_last                   in_valid && in_ready
// out      output     out_valid_res, out_major_value,         out_valid && out_ready
//                     out_minor_value, out_patch_value,
//                     out_pre_offset, out_pre_length
// one byte per cycle sustained while no unread result blocks the output; a byte is held
// in the input register, then the phase update and times-ten accumulate are computed and registered
// a result is offered from the output register, loaded as its last byte leaves the input register
// a last byte waits in the input register while an unread result blocks the output
// reset is synchronous, active low, and leaves the parser in the major number phase
`include "semver_string_validator_macros.svh"

module semver_string_validator #(
  parameter int MAX_LEN    = 1024,
  parameter int MAX_DIGITS = 18
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_char_code,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_valid_res,
  output svs_pkg::num_t       out_major_value,
  output svs_pkg::num_t       out_minor_value,
  output svs_pkg::num_t       out_patch_value,
  output svs_pkg::ofs_t       out_pre_offset,
  output svs_pkg::ofs_t       out_pre_length
);

  localparam int PW = $clog2(MAX_LEN + 2);
  localparam int XW = (PW + 1 > svs_pkg::OFS_W) ? PW + 1 : svs_pkg::OFS_W;
  localparam logic [PW-1:0] LEN_LIM = PW'(MAX_LEN);
  localparam logic [svs_pkg::DCNT_W-1:0] DIG_LIM = svs_pkg::DCNT_W'(MAX_DIGITS);

  // input register
  logic       s1_v_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;
  logic       s1_adv;

  // parser state
  logic [2:0]                   phase_r, phase_nxt;
  svs_pkg::num_t                acc_r, acc_nxt;
  logic [svs_pkg::DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic                         lead_zero_r, lead_zero_nxt;
  svs_pkg::num_t                major_r, major_nxt;
  svs_pkg::num_t                minor_r, minor_nxt;
  logic [1:0]                   id_len_r, id_len_nxt;
  logic                         id_all_dig_r, id_all_dig_nxt;
  logic                         id_first_zero_r, id_first_zero_nxt;
  logic [PW-1:0]                pos_r, pos_nxt;
  logic                         has_pre_r, has_pre_nxt;
  svs_pkg::ofs_t                pre_start_r, pre_start_nxt;
  svs_pkg::ofs_t                pre_end_r, pre_end_nxt;

  // output register
  logic          out_valid_r;
  logic          res_ok_r;
  svs_pkg::num_t major_out_r, minor_out_r, patch_out_r;
  svs_pkg::ofs_t pre_ofs_r, pre_len_r;

  // combinational helpers
  logic [XW-1:0] idx_cur;
  logic [XW-1:0] idx_p1;
  logic          is_digit, is_ident;
  logic          close_strict, close_loose;
  logic          res_ok;
  svs_pkg::ofs_t pre_end_fin;

  assign s1_adv   = s1_v_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;

  assign idx_cur  = XW'(pos_r);
  assign idx_p1   = idx_cur + XW'(1);
  assign is_digit = s1_char_r inside {[svs_pkg::CH_ZERO:svs_pkg::CH_NINE]};
  assign is_ident = is_digit || s1_char_r == svs_pkg::CH_DASH
                  || s1_char_r inside {[svs_pkg::CH_UC_A:svs_pkg::CH_UC_Z]}
                  || s1_char_r inside {[svs_pkg::CH_LC_A:svs_pkg::CH_LC_Z]};

  always_comb begin
    phase_nxt         = phase_r;
    acc_nxt           = acc_r;
    dcnt_nxt          = dcnt_r;
    lead_zero_nxt     = lead_zero_r;
    major_nxt         = major_r;
    minor_nxt         = minor_r;
    id_len_nxt        = id_len_r;
    id_all_dig_nxt    = id_all_dig_r;
    id_first_zero_nxt = id_first_zero_r;
    has_pre_nxt       = has_pre_r;
    pre_start_nxt     = pre_start_r;
    pre_end_nxt       = pre_end_r;
    pos_nxt           = (pos_r <= LEN_LIM) ? pos_r + PW'(1) : pos_r;

    if (pos_r >= LEN_LIM || s1_char_r == svs_pkg::CH_NUL) begin
      phase_nxt = svs_pkg::PH_ERR;
    end

    case (phase_nxt)
      svs_pkg::PH_MAJOR, svs_pkg::PH_MINOR, svs_pkg::PH_PATCH: begin
        if (is_digit) begin
          if (dcnt_r != '0 && lead_zero_r) begin
            phase_nxt = svs_pkg::PH_ERR;
          end else if (dcnt_r >= DIG_LIM) begin
            phase_nxt = svs_pkg::PH_ERR;
          end else begin
            if (dcnt_r == '0) begin
              lead_zero_nxt = (s1_char_r == svs_pkg::CH_ZERO);
            end
            dcnt_nxt = dcnt_r + svs_pkg::DCNT_W'(1);
            acc_nxt  = (acc_r << 3) + (acc_r << 1)
                     + svs_pkg::NUM_W'(s1_char_r[3:0]);
          end
        end else if (dcnt_r == '0) begin
          phase_nxt = svs_pkg::PH_ERR;
        end else if (s1_char_r == svs_pkg::CH_DOT && phase_nxt != svs_pkg::PH_PATCH) begin
          if (phase_nxt == svs_pkg::PH_MAJOR) begin
            major_nxt = acc_r;
            phase_nxt = svs_pkg::PH_MINOR;
          end else begin
            minor_nxt = acc_r;
            phase_nxt = svs_pkg::PH_PATCH;
          end
          acc_nxt       = '0;
          dcnt_nxt      = '0;
          lead_zero_nxt = 1'b0;
        end else if (s1_char_r == svs_pkg::CH_DASH && phase_nxt == svs_pkg::PH_PATCH) begin
          has_pre_nxt       = 1'b1;
          pre_start_nxt     = idx_p1[svs_pkg::OFS_W-1:0];
          phase_nxt         = svs_pkg::PH_PRE;
          id_len_nxt        = 2'd0;
          id_all_dig_nxt    = 1'b1;
          id_first_zero_nxt = 1'b0;
        end else if (s1_char_r == svs_pkg::CH_PLUS && phase_nxt == svs_pkg::PH_PATCH) begin
          phase_nxt         = svs_pkg::PH_BUILD;
          id_len_nxt        = 2'd0;
          id_all_dig_nxt    = 1'b1;
          id_first_zero_nxt = 1'b0;
        end else begin
          phase_nxt = svs_pkg::PH_ERR;
        end
      end
      svs_pkg::PH_PRE, svs_pkg::PH_BUILD: begin
        if (s1_char_r == svs_pkg::CH_DOT) begin
          if (id_len_r == 2'd0 || (phase_nxt == svs_pkg::PH_PRE && id_all_dig_r
              && id_len_r == 2'd2 && id_first_zero_r)) begin
            phase_nxt = svs_pkg::PH_ERR;
          end
          id_len_nxt        = 2'd0;
          id_all_dig_nxt    = 1'b1;
          id_first_zero_nxt = 1'b0;
        end else if (s1_char_r == svs_pkg::CH_PLUS && phase_nxt == svs_pkg::PH_PRE) begin
          if (id_len_r == 2'd0 || (id_all_dig_r && id_len_r == 2'd2 && id_first_zero_r)) begin
            phase_nxt = svs_pkg::PH_ERR;
          end else begin
            pre_end_nxt = idx_cur[svs_pkg::OFS_W-1:0];
            phase_nxt   = svs_pkg::PH_BUILD;
          end
          id_len_nxt        = 2'd0;
          id_all_dig_nxt    = 1'b1;
          id_first_zero_nxt = 1'b0;
        end else if (is_ident) begin
          if (id_len_r == 2'd0) begin
            id_first_zero_nxt = (s1_char_r == svs_pkg::CH_ZERO);
          end
          if (!is_digit) begin
            id_all_dig_nxt = 1'b0;
          end
          if (id_len_r != 2'd2) begin
            id_len_nxt = id_len_r + 2'd1;
          end
        end else begin
          phase_nxt = svs_pkg::PH_ERR;
        end
      end
      default: begin
      end
    endcase
  end

  // end-of-string checks on the updated state
  assign close_loose  = (id_len_nxt != 2'd0);
  assign close_strict = close_loose
                      && !(id_all_dig_nxt && id_len_nxt == 2'd2 && id_first_zero_nxt);

  always_comb begin
    res_ok      = 1'b0;
    pre_end_fin = pre_end_nxt;
    case (phase_nxt)
      svs_pkg::PH_PATCH: res_ok = (dcnt_nxt != '0);
      svs_pkg::PH_PRE: begin
        res_ok      = close_strict;
        pre_end_fin = idx_p1[svs_pkg::OFS_W-1:0];
      end
      svs_pkg::PH_BUILD: res_ok = close_loose;
      default: res_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
    if (in_valid && in_ready) begin
      s1_char_r <= in_char_code;
      s1_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (s1_adv && s1_last_r)) begin
      phase_r         <= svs_pkg::PH_MAJOR;
      acc_r           <= '0;
      dcnt_r          <= '0;
      lead_zero_r     <= 1'b0;
      major_r         <= '0;
      minor_r         <= '0;
      id_len_r        <= 2'd0;
      id_all_dig_r    <= 1'b1;
      id_first_zero_r <= 1'b0;
      pos_r           <= '0;
      has_pre_r       <= 1'b0;
      pre_start_r     <= '0;
      pre_end_r       <= '0;
    end else if (s1_adv) begin
      phase_r         <= phase_nxt;
      acc_r           <= acc_nxt;
      dcnt_r          <= dcnt_nxt;
      lead_zero_r     <= lead_zero_nxt;
      major_r         <= major_nxt;
      minor_r         <= minor_nxt;
      id_len_r        <= id_len_nxt;
      id_all_dig_r    <= id_all_dig_nxt;
      id_first_zero_r <= id_first_zero_nxt;
      pos_r           <= pos_nxt;
      has_pre_r       <= has_pre_nxt;
      pre_start_r     <= pre_start_nxt;
      pre_end_r       <= pre_end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv && s1_last_r) begin
      res_ok_r    <= res_ok;
      major_out_r <= res_ok ? major_nxt : '0;
      minor_out_r <= res_ok ? minor_nxt : '0;
      patch_out_r <= res_ok ? acc_nxt : '0;
      pre_ofs_r   <= (res_ok && has_pre_nxt) ? pre_start_nxt : '0;
      pre_len_r   <= (res_ok && has_pre_nxt) ? pre_end_fin - pre_start_nxt : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_valid_res   = res_ok_r;
  assign out_major_value = major_out_r;
  assign out_minor_value = minor_out_r;
  assign out_patch_value = patch_out_r;
  assign out_pre_offset  = pre_ofs_r;
  assign out_pre_length  = pre_len_r;

  `SVS_ASSERT_NEXT(a_last_gives_result, clk, rst_n, s1_adv && s1_last_r, out_valid_r)
  `SVS_ASSERT_NEXT(a_restart_after_last, clk, rst_n, s1_adv && s1_last_r,
                   phase_r == svs_pkg::PH_MAJOR && dcnt_r == '0 && pos_r == '0)
  `SVS_ASSERT_NEXT(a_error_sticks, clk, rst_n,
                   phase_r == svs_pkg::PH_ERR && !(s1_adv && s1_last_r),
                   phase_r == svs_pkg::PH_ERR)
  `SVS_ASSERT_NOW(a_invalid_zero_fields, clk, rst_n, out_valid_r && !res_ok_r,
                  major_out_r == '0 && minor_out_r == '0 && patch_out_r == '0
                  && pre_ofs_r == '0 && pre_len_r == '0)

endmodule
